// ===== rtl/irpt_pkg.sv =====
// ----------------------------------------------------------------------------
// irpt_pkg
// shared types, constants and codes of the ir pulse train transmitter
// ----------------------------------------------------------------------------
package irpt_pkg;

    // sizing
    localparam int MAX_BITS    = 32;
    localparam int TABLE_DEPTH = 64;
    localparam int TICK_W      = 16;
    localparam int IDX_W       = 6;
    localparam int LEN_W       = 7;
    localparam int CODE_W      = 32;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    // request function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_RAW   = 2'd2;
    localparam logic [1:0] FUNC_GEN   = 2'd3;

    // register indexes
    localparam logic [1:0] REG_ONE_ON   = 2'd0;
    localparam logic [1:0] REG_ONE_OFF  = 2'd1;
    localparam logic [1:0] REG_ZERO_ON  = 2'd2;
    localparam logic [1:0] REG_ZERO_OFF = 2'd3;

    // timing registers
    typedef struct packed {
        logic [TICK_W-1:0] one_on;
        logic [TICK_W-1:0] one_off;
        logic [TICK_W-1:0] zero_on;
        logic [TICK_W-1:0] zero_off;
    } timing_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic tick;
        logic write_entry;
        logic raw_start;
        logic gen_check;
        logic gen_write;
        logic gen_start;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic gen_len_ok;
        logic gen_last;
    } dp_status_t;

endpackage

// ===== rtl/irpt_regs.sv =====
// ----------------------------------------------------------------------------
// irpt_regs
// apb register file holding the four bit timing registers
// ----------------------------------------------------------------------------
module irpt_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [irpt_pkg::ADDR_W-1:0]  paddr,
    input  logic [irpt_pkg::DATA_W-1:0]  pwdata,
    output logic [irpt_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output irpt_pkg::timing_t            timing
);
    import irpt_pkg::*;

    timing_t    timing_reg;
    timing_t    timing_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];
    assign timing  = timing_reg;

    // write decode
    always_comb
    begin
        timing_next = timing_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_ONE_ON:   timing_next.one_on   = pwdata[TICK_W-1:0];
                REG_ONE_OFF:  timing_next.one_off  = pwdata[TICK_W-1:0];
                REG_ZERO_ON:  timing_next.zero_on  = pwdata[TICK_W-1:0];
                REG_ZERO_OFF: timing_next.zero_off = pwdata[TICK_W-1:0];
                default:      timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg <= '0;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

    // read mux
    always_comb
    begin
        case (reg_sel)
            REG_ONE_ON:   prdata = DATA_W'(timing_reg.one_on);
            REG_ONE_OFF:  prdata = DATA_W'(timing_reg.one_off);
            REG_ZERO_ON:  prdata = DATA_W'(timing_reg.zero_on);
            REG_ZERO_OFF: prdata = DATA_W'(timing_reg.zero_off);
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== rtl/irpt_dp.sv =====
// ----------------------------------------------------------------------------
// irpt_dp
// datapath: pulse table memory, send state, tick counter, code expansion
// ----------------------------------------------------------------------------
module irpt_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  irpt_pkg::dp_cmd_t            cmd,
    output irpt_pkg::dp_status_t         status,
    input  irpt_pkg::timing_t            timing,
    input  logic [irpt_pkg::IDX_W-1:0]   entry_index,
    input  logic [irpt_pkg::TICK_W-1:0]  entry_ticks,
    input  logic [irpt_pkg::LEN_W-1:0]   code_length,
    input  logic [irpt_pkg::CODE_W-1:0]  bit_code,
    output logic                         carrier_on,
    output logic                         busy_res,
    output logic                         rejected
);
    import irpt_pkg::*;

    // captured request
    logic [IDX_W-1:0]  idx_reg;
    logic [TICK_W-1:0] ticks_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;

    // send state
    logic [LEN_W-1:0]  pulse_index_reg;
    logic [LEN_W-1:0]  pulse_index_next;
    logic [LEN_W-1:0]  send_length_reg;
    logic [LEN_W-1:0]  send_length_next;
    logic [TICK_W-1:0] tick_count_reg;
    logic [TICK_W-1:0] tick_count_next;
    logic              gate_reg;
    logic              gate_next;
    logic              rej_reg;
    logic              rej_next;

    // expansion counter
    logic [IDX_W-1:0]  wcnt_reg;
    logic [IDX_W-1:0]  wcnt_next;

    // pulse table
    logic [TICK_W-1:0] mem [0:TABLE_DEPTH-1];
    logic [TICK_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [TICK_W-1:0] mem_wdata;

    logic              active;
    logic              raw_ok;
    logic [LEN_W:0]    len_x2;
    logic [TICK_W-1:0] tick_inc;
    logic [LEN_W-1:0]  index_inc;
    logic [LEN_W-1:0]  gen_pulses;

    assign active     = pulse_index_reg < send_length_reg;
    assign raw_ok     = (len_reg != '0) && (len_reg <= LEN_W'(TABLE_DEPTH));
    assign len_x2     = {len_reg, 1'b0};
    assign tick_inc   = tick_count_reg + TICK_W'(1);
    assign index_inc  = pulse_index_reg + LEN_W'(1);
    assign gen_pulses = len_x2[LEN_W-1:0] - LEN_W'(1);

    assign status.gen_len_ok = (len_reg != '0) && (len_reg <= LEN_W'(MAX_BITS))
                               && (len_x2 <= (LEN_W+1)'(TABLE_DEPTH));
    assign status.gen_last   = (wcnt_reg == '0);

    assign carrier_on = gate_reg;
    assign busy_res   = active;
    assign rejected   = rej_reg;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg   <= entry_index;
            ticks_reg <= entry_ticks;
            len_reg   <= code_length;
        end
        code_reg <= code_next;
    end

    // expansion walks entries from the top down, taking code bits lsb first
    always_comb
    begin
        code_next = code_reg;
        if (cmd.load)
        begin
            code_next = bit_code;
        end
        else if (cmd.gen_write && !wcnt_reg[0])
        begin
            code_next = code_reg >> 1;
        end
    end

    // memory write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = ticks_reg;
        if (cmd.write_entry)
        begin
            mem_we = ({1'b0, idx_reg} < (IDX_W+1)'(TABLE_DEPTH));
        end
        else if (cmd.gen_write)
        begin
            mem_we    = 1'b1;
            mem_waddr = wcnt_reg;
            case ({code_reg[0], wcnt_reg[0]})
                2'b00:   mem_wdata = timing.zero_on;
                2'b01:   mem_wdata = timing.zero_off;
                2'b10:   mem_wdata = timing.one_on;
                2'b11:   mem_wdata = timing.one_off;
                default: mem_wdata = timing.zero_on;
            endcase
        end
    end

    // pulse table with registered read at the current pulse index
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[pulse_index_reg[IDX_W-1:0]];
    end

    // send state update
    always_comb
    begin
        pulse_index_next = pulse_index_reg;
        send_length_next = send_length_reg;
        tick_count_next  = tick_count_reg;
        gate_next        = gate_reg;
        rej_next         = rej_reg;
        wcnt_next        = wcnt_reg;
        if (cmd.load)
        begin
            rej_next = 1'b0;
        end
        if (cmd.tick && active)
        begin
            if (tick_inc >= rd_data_reg)
            begin
                pulse_index_next = index_inc;
                gate_next        = ~index_inc[0];
                tick_count_next  = '0;
            end
            else
            begin
                tick_count_next = tick_inc;
            end
        end
        if (cmd.raw_start)
        begin
            pulse_index_next = '0;
            tick_count_next  = '0;
            if (raw_ok)
            begin
                send_length_next = (len_reg - LEN_W'(1)) | LEN_W'(1);
                gate_next        = 1'b1;
            end
            else
            begin
                send_length_next = '0;
                gate_next        = 1'b0;
                rej_next         = 1'b1;
            end
        end
        if (cmd.gen_check)
        begin
            wcnt_next = gen_pulses[IDX_W-1:0];
            if (!status.gen_len_ok)
            begin
                pulse_index_next = '0;
                send_length_next = '0;
                tick_count_next  = '0;
                gate_next        = 1'b0;
                rej_next         = 1'b1;
            end
        end
        if (cmd.gen_write && !status.gen_last)
        begin
            wcnt_next = wcnt_reg - IDX_W'(1);
        end
        if (cmd.gen_start)
        begin
            pulse_index_next = '0;
            tick_count_next  = '0;
            send_length_next = gen_pulses;
            gate_next        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_index_reg <= '0;
            send_length_reg <= '0;
            tick_count_reg  <= '0;
            gate_reg        <= 1'b0;
            rej_reg         <= 1'b0;
            wcnt_reg        <= '0;
        end
        else
        begin
            pulse_index_reg <= pulse_index_next;
            send_length_reg <= send_length_next;
            tick_count_reg  <= tick_count_next;
            gate_reg        <= gate_next;
            rej_reg         <= rej_next;
            wcnt_reg        <= wcnt_next;
        end
    end

endmodule

// ===== rtl/irpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// irpt_ctrl
// controller state machine sequencing each request through the datapath
// ----------------------------------------------------------------------------
module irpt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            func,
    input  irpt_pkg::dp_status_t  status,
    output irpt_pkg::dp_cmd_t     cmd,
    output logic                  busy,
    output logic                  done
);
    import irpt_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_TICK_RD  = 3'd1;
    localparam logic [2:0] S_TICK_UPD = 3'd2;
    localparam logic [2:0] S_WRITE    = 3'd3;
    localparam logic [2:0] S_RAW      = 3'd4;
    localparam logic [2:0] S_GEN_CHK  = 3'd5;
    localparam logic [2:0] S_GEN      = 3'd6;
    localparam logic [2:0] S_RESP     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (func)
                        FUNC_TICK:  state_next = S_TICK_RD;
                        FUNC_WRITE: state_next = S_WRITE;
                        FUNC_RAW:   state_next = S_RAW;
                        FUNC_GEN:   state_next = S_GEN_CHK;
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_TICK_RD:
            begin
                state_next = S_TICK_UPD;
            end
            S_TICK_UPD:
            begin
                cmd.tick   = 1'b1;
                state_next = S_RESP;
            end
            S_WRITE:
            begin
                cmd.write_entry = 1'b1;
                state_next      = S_RESP;
            end
            S_RAW:
            begin
                cmd.raw_start = 1'b1;
                state_next    = S_RESP;
            end
            S_GEN_CHK:
            begin
                cmd.gen_check = 1'b1;
                state_next    = status.gen_len_ok ? S_GEN : S_RESP;
            end
            S_GEN:
            begin
                cmd.gen_write = 1'b1;
                if (status.gen_last)
                begin
                    cmd.gen_start = 1'b1;
                    state_next    = S_RESP;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/ir_pulse_train_transmitter.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_train_transmitter
// ir remote transmitter gating a carrier from a table of on/off pulse lengths
// ----------------------------------------------------------------------------
//  channel   handshake                      payload
//  request   start, busy (taken: start&!busy) func, entry_index, entry_ticks,
//                                           code_length, bit_code
//  result    done (one cycle strobe)        carrier_on, busy_res, rejected
//  config    apb psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  tick: S_TICK_RD, then S_TICK_UPD, then the result strobe
//  entry write, raw start, rejected start: S_WRITE, S_RAW or S_GEN_CHK, then the strobe
//  bit code start: S_GEN_CHK then S_GEN, one pulse table write port, one entry a cycle
//  reset clears the send state and timing registers; the table is not cleared
//  busy stays high until the strobe cycle is over; the receiver cannot stall
// ----------------------------------------------------------------------------
module ir_pulse_train_transmitter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   func,
    input  logic [irpt_pkg::IDX_W-1:0]   entry_index,
    input  logic [irpt_pkg::TICK_W-1:0]  entry_ticks,
    input  logic [irpt_pkg::LEN_W-1:0]   code_length,
    input  logic [irpt_pkg::CODE_W-1:0]  bit_code,
    output logic                         done,
    output logic                         carrier_on,
    output logic                         busy_res,
    output logic                         rejected,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [irpt_pkg::ADDR_W-1:0]  paddr,
    input  logic [irpt_pkg::DATA_W-1:0]  pwdata,
    output logic [irpt_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import irpt_pkg::*;

    timing_t    timing;
    dp_cmd_t    cmd;
    dp_status_t status;

    // timing registers
    irpt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .timing  (timing)
    );

    // sequencing
    irpt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // table, counters and send state
    irpt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .timing      (timing),
        .entry_index (entry_index),
        .entry_ticks (entry_ticks),
        .code_length (code_length),
        .bit_code    (bit_code),
        .carrier_on  (carrier_on),
        .busy_res    (busy_res),
        .rejected    (rejected)
    );

endmodule
